FILE: hw/rtl/dlr_pkg.sv
// ---------------------------------------------------------------------------
// dlr_pkg
// shared types and constants of the dda line rasterizer
// ---------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int STEP_W     = COORD_BITS + 1;
    localparam int POS_W      = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W      = FRAC_BITS + 2;
    localparam int NUM_W      = COORD_BITS + FRAC_BITS;
    localparam int MOD_W      = 4;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] STYLE_SIMPLE = 2'd0;
    localparam logic [1:0] STYLE_DOTTED = 2'd1;
    localparam logic [1:0] STYLE_DASHED = 2'd2;
    localparam logic [1:0] STYLE_SOLID  = 2'd3;

    localparam logic [MOD_W-1:0] PATTERN_LAST = MOD_W'(9);
    localparam logic [MOD_W-1:0] PATTERN_HALF = MOD_W'(5);

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         plot;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        logic                         is_start;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic        [COORD_BITS-1:0] mag_x;
        logic        [COORD_BITS-1:0] mag_y;
        logic                         neg_x;
        logic                         neg_y;
        logic        [COORD_BITS-1:0] steps;
    } cmd_entry_t;

    typedef struct packed {
        logic dividing;
        logic line_active;
        logic emit;
        logic emit_last;
    } back_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlr_front.sv
// ---------------------------------------------------------------------------
// dlr_front
// accepts requests, works out deltas and step count, queues them
// ---------------------------------------------------------------------------
`default_nettype none

module dlr_front #(
    parameter int DEPTH = 4
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    output logic                  full,
    input  dlr_pkg::in_item_t     in_item,
    output logic                  cmd_valid,
    output dlr_pkg::cmd_entry_t   cmd_head,
    input  wire                   cmd_pop
);
    import dlr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_entry_t              queue_mem [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    do_push, do_pop;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]     abs_x, abs_y;
    cmd_entry_t              entry;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = queue_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // classify and precompute the line setup
    always_comb
    begin
        dx = {in_item.end_x[COORD_BITS-1], in_item.end_x}
           - {in_item.start_x[COORD_BITS-1], in_item.start_x};
        dy = {in_item.end_y[COORD_BITS-1], in_item.end_y}
           - {in_item.start_y[COORD_BITS-1], in_item.start_y};
        abs_x = dx[COORD_BITS] ? -dx : dx;
        abs_y = dy[COORD_BITS] ? -dy : dy;
        entry.is_start = (in_item.command == CMD_START);
        entry.x1       = in_item.start_x;
        entry.y1       = in_item.start_y;
        entry.mag_x    = abs_x[COORD_BITS-1:0];
        entry.mag_y    = abs_y[COORD_BITS-1:0];
        entry.neg_x    = dx[COORD_BITS];
        entry.neg_y    = dy[COORD_BITS];
        entry.steps    = (abs_x > abs_y) ? abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_div.sv
// ---------------------------------------------------------------------------
// dlr_div
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module dlr_div (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [dlr_pkg::NUM_W-1:0]        num_a,
    input  wire  [dlr_pkg::NUM_W-1:0]        num_b,
    input  wire  [dlr_pkg::COORD_BITS-1:0]   den,
    output logic                             done,
    output logic [dlr_pkg::NUM_W-1:0]        quo_a,
    output logic [dlr_pkg::NUM_W-1:0]        quo_b
);
    import dlr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [NUM_W-1:0]      num_a_reg, num_a_next, num_b_reg, num_b_next;
    logic [COORD_BITS-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [COORD_BITS:0]   sh_a, sh_b;
    logic                  ge_a, ge_b;

    assign done  = done_reg;
    assign quo_a = num_a_reg;
    assign quo_b = num_b_reg;

    always_comb
    begin
        sh_a = {rem_a_reg, num_a_reg[NUM_W-1]};
        sh_b = {rem_b_reg, num_b_reg[NUM_W-1]};
        ge_a = (sh_a >= {1'b0, den_reg});
        ge_b = (sh_b >= {1'b0, den_reg});
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_a_next = num_a_reg;
        num_b_next = num_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        den_next   = den_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(NUM_W);
            num_a_next = num_a;
            num_b_next = num_b;
            rem_a_next = '0;
            rem_b_next = '0;
            den_next   = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == CNT_W'(1));
            rem_a_next = ge_a ? COORD_BITS'(sh_a - {1'b0, den_reg}) : COORD_BITS'(sh_a);
            rem_b_next = ge_b ? COORD_BITS'(sh_b - {1'b0, den_reg}) : COORD_BITS'(sh_b);
            num_a_next = {num_a_reg[NUM_W-2:0], ge_a};
            num_b_next = {num_b_reg[NUM_W-2:0], ge_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        den_reg   <= den_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_back.sv
// ---------------------------------------------------------------------------
// dlr_back
// line setup and point stepping, style pattern and result register
// ---------------------------------------------------------------------------
`default_nettype none

module dlr_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        style_we,
    input  wire  [1:0]                 style_wdata,
    input  wire                        cmd_valid,
    input  dlr_pkg::cmd_entry_t        cmd_head,
    output logic                       cmd_pop,
    output logic                       empty,
    input  wire                        pop,
    output dlr_pkg::out_item_t         out_item,
    output dlr_pkg::back_stat_t        stat
);
    import dlr_pkg::*;

    typedef enum logic {ST_RUN, ST_DIV} state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              style_reg;
    logic                    active_reg, active_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;
    logic signed [POS_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [INC_W-1:0] inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [STEP_W-1:0]       idx_reg, idx_next, total_reg, total_next;
    logic [MOD_W-1:0]        mod_reg, mod_next;
    logic                    neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        quo_x, quo_y;
    logic                    out_free, emit, is_last, plot_bit;
    logic [COORD_BITS-1:0]   px, py;

    dlr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_a ({cmd_head.mag_x, FRAC_BITS'(0)}),
        .num_b ({cmd_head.mag_y, FRAC_BITS'(0)}),
        .den   (cmd_head.steps),
        .done  (div_done),
        .quo_a (quo_x),
        .quo_b (quo_y)
    );

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign is_last  = (idx_reg >= total_reg);

    // current point truncated toward zero
    always_comb
    begin
        px = pos_x_reg[FRAC_BITS +: COORD_BITS]
           + COORD_BITS'(pos_x_reg[POS_W-1] && (pos_x_reg[FRAC_BITS-1:0] != '0));
        py = pos_y_reg[FRAC_BITS +: COORD_BITS]
           + COORD_BITS'(pos_y_reg[POS_W-1] && (pos_y_reg[FRAC_BITS-1:0] != '0));
        case (style_reg)
            STYLE_DOTTED: plot_bit = (mod_reg == '0) || (mod_reg == PATTERN_HALF);
            STYLE_DASHED: plot_bit = (mod_reg < PATTERN_HALF);
            default:      plot_bit = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        inc_x_next     = inc_x_reg;
        inc_y_next     = inc_y_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        mod_next       = mod_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        cmd_pop        = 1'b0;
        div_start      = 1'b0;
        emit           = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (cmd_valid && cmd_head.is_start)
                begin
                    cmd_pop     = 1'b1;
                    pos_x_next  = {cmd_head.x1[COORD_BITS-1], cmd_head.x1, FRAC_BITS'(0)};
                    pos_y_next  = {cmd_head.y1[COORD_BITS-1], cmd_head.y1, FRAC_BITS'(0)};
                    total_next  = {1'b0, cmd_head.steps};
                    idx_next    = '0;
                    mod_next    = '0;
                    neg_x_next  = cmd_head.neg_x;
                    neg_y_next  = cmd_head.neg_y;
                    active_next = 1'b1;
                    inc_x_next  = '0;
                    inc_y_next  = '0;
                    if (cmd_head.steps != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else if (cmd_valid && !active_reg)
                begin
                    cmd_pop = 1'b1;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '{pixel_x: px, pixel_y: py, plot: plot_bit, last: is_last};
                    if (is_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        pos_x_next = pos_x_reg + {{(POS_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
                        pos_y_next = pos_y_reg + {{(POS_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
                        idx_next   = idx_reg + 1'b1;
                        mod_next   = (mod_reg == PATTERN_LAST) ? '0 : mod_reg + 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    inc_x_next = neg_x_reg ? -quo_x[INC_W-1:0] : quo_x[INC_W-1:0];
                    inc_y_next = neg_y_reg ? -quo_y[INC_W-1:0] : quo_y[INC_W-1:0];
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            style_reg     <= STYLE_SIMPLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (style_we)
            begin
                style_reg <= style_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        inc_x_reg <= inc_x_next;
        inc_y_reg <= inc_y_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        mod_reg   <= mod_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
    end

    assign stat = '{dividing: (state_reg == ST_DIV), line_active: active_reg,
                    emit: emit, emit_last: is_last};

endmodule

`default_nettype wire

FILE: hw/rtl/dda_line_rasterizer_with_patterns_core.sv
// ---------------------------------------------------------------------------
// dda_line_rasterizer_with_patterns_core
// dda line stepper: start requests set up a line, advance requests give points
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        in_item  (command, start_x/y, end_x/y)
//  result    empty / pop        out_item (pixel_x/y, plot, last)
//  config    style_we           style_wdata (line style)
//
//  advance requests give one point per cycle while results are taken
//  a start request with distinct endpoints holds the stepper while the
//  shared restoring divider works out the increments, one quotient bit per cycle
//  requests queue in front of the stepper and keep arriving during a divide
//  reset clears the queue, the line and the result register at once
// ---------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_with_patterns_core #(
    parameter int CMD_DEPTH = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  dlr_pkg::in_item_t    in_item,
    output logic                 empty,
    input  wire                  pop,
    output dlr_pkg::out_item_t   out_item,
    input  wire                  style_we,
    input  wire  [1:0]           style_wdata
);
    import dlr_pkg::*;

    logic       cmd_valid;
    logic       cmd_pop;
    cmd_entry_t cmd_head;
    back_stat_t stat;

    dlr_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    dlr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .style_we    (style_we),
        .style_wdata (style_wdata),
        .cmd_valid   (cmd_valid),
        .cmd_head    (cmd_head),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .stat        (stat)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    a_no_pop_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat.dividing |-> !cmd_pop)
        else $error("request taken during divide");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.emit && stat.emit_last) |=> !stat.line_active)
        else $error("line still active after last point");

    a_emit_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emit |=> !empty)
        else $error("emitted point not held");

endmodule

`default_nettype wire

FILE: tb/sv/tb_dda_line_rasterizer_with_patterns_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dda_line_rasterizer_with_patterns_core
// Self-checking testbench for the DDA line stepper. A built-in predictor
// follows every accepted request and queues the points it should produce.
// Each popped point is then compared against the oldest queued point.
// The run covers directed corner cases, random lines under every line
// style, a long receiver hold-off and a stretch with no idling.
// ---------------------------------------------------------------------------

module tb_dda_line_rasterizer_with_patterns_core;

    import dlr_pkg::*;

    localparam int     COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int     COORD_MIN    = -COORD_MAX - 1;
    localparam longint FIX_ONE      = longint'(1) << FRAC_BITS;
    localparam int     IN_W         = $bits(in_item_t);
    localparam int     DOT_PERIOD   = 5;
    localparam int     DASH_PERIOD  = 10;
    localparam int     DASH_ON      = 5;
    localparam int     IDLE_PCT     = 37;
    localparam int     SETTLE_WAIT  = 200;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     MAX_REPORTS  = 10;
    localparam longint CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;
    logic        style_we = 1'b0;
    logic [1:0]  style_wdata = STYLE_SIMPLE;

    // predicted line state
    logic signed [POS_W-1:0]  ln_pos_x = '0;
    logic signed [POS_W-1:0]  ln_pos_y = '0;
    logic signed [INC_W-1:0]  ln_inc_x = '0;
    logic signed [INC_W-1:0]  ln_inc_y = '0;
    logic        [STEP_W-1:0] ln_step = '0;
    logic        [STEP_W-1:0] ln_total = '0;
    logic                     ln_active = 1'b0;
    logic        [1:0]        ln_style = STYLE_SIMPLE;

    out_item_t pending_points[$];
    int        mismatches = 0;
    int        open_points = 0;
    int        useful_sent = 0;
    int        hold_req = 0;
    bit        no_idle = 1'b0;
    longint    cycle_count = 0;

    dda_line_rasterizer_with_patterns_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item),
        .style_we    (style_we),
        .style_wdata (style_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void rasterize_request(input in_item_t req);
        longint    dx;
        longint    dy;
        longint    steps;
        longint    px;
        longint    py;
        out_item_t pt;
        if (req.command == CMD_START)
        begin
            dx = longint'($signed(req.end_x)) - longint'($signed(req.start_x));
            dy = longint'($signed(req.end_y)) - longint'($signed(req.start_y));
            steps = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > steps)
                steps = (dy < 0) ? -dy : dy;
            ln_pos_x = POS_W'(longint'($signed(req.start_x)) * FIX_ONE);
            ln_pos_y = POS_W'(longint'($signed(req.start_y)) * FIX_ONE);
            if (steps == 0)
            begin
                ln_inc_x = '0;
                ln_inc_y = '0;
            end
            else
            begin
                ln_inc_x = INC_W'((dx * FIX_ONE) / steps);
                ln_inc_y = INC_W'((dy * FIX_ONE) / steps);
            end
            ln_total = STEP_W'(steps);
            ln_step = '0;
            ln_active = 1'b1;
            return;
        end
        if (!ln_active)
            return;
        px = longint'(ln_pos_x) / FIX_ONE;
        py = longint'(ln_pos_y) / FIX_ONE;
        pt.pixel_x = COORD_BITS'(px);
        pt.pixel_y = COORD_BITS'(py);
        case (ln_style)
            STYLE_DOTTED: pt.plot = (ln_step % DOT_PERIOD) == 0;
            STYLE_DASHED: pt.plot = (ln_step % DASH_PERIOD) < DASH_ON;
            default:      pt.plot = 1'b1;
        endcase
        pt.last = (ln_step >= ln_total);
        pending_points.push_back(pt);
        if (pt.last)
            ln_active = 1'b0;
        else
        begin
            ln_pos_x = ln_pos_x + ln_inc_x;
            ln_pos_y = ln_pos_y + ln_inc_y;
            ln_step = ln_step + 1'b1;
        end
    endfunction

    function automatic void note_error(input string what, input longint want,
                                       input longint got);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endfunction

    function automatic void check_point(input out_item_t got);
        out_item_t want;
        if (pending_points.size() == 0)
        begin
            note_error("unexpected point x", 0, got.pixel_x);
            return;
        end
        want = pending_points.pop_front();
        if (got.pixel_x !== want.pixel_x)
            note_error("pixel_x", want.pixel_x, got.pixel_x);
        if (got.pixel_y !== want.pixel_y)
            note_error("pixel_y", want.pixel_y, got.pixel_y);
        if (got.plot !== want.plot)
            note_error("plot", want.plot, got.plot);
        if (got.last !== want.last)
            note_error("last", want.last, got.last);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (style_we)
                ln_style = style_wdata;
            if (push && !full)
                rasterize_request(in_item);
            if (pop && !empty)
                check_point(out_item);
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic int line_span(input in_item_t req);
        int ax;
        int ay;
        ax = int'($signed(req.end_x)) - int'($signed(req.start_x));
        ay = int'($signed(req.end_y)) - int'($signed(req.start_y));
        ax = (ax < 0) ? -ax : ax;
        ay = (ay < 0) ? -ay : ay;
        return (ax > ay) ? ax : ay;
    endfunction

    function automatic in_item_t start_req(input int sx, input int sy,
                                           input int ex, input int ey);
        in_item_t req;
        req.command = CMD_START;
        req.start_x = COORD_BITS'(sx);
        req.start_y = COORD_BITS'(sy);
        req.end_x   = COORD_BITS'(ex);
        req.end_y   = COORD_BITS'(ey);
        return req;
    endfunction

    function automatic in_item_t rand_advance();
        in_item_t req;
        req = IN_W'({$urandom, $urandom});
        req.command = CMD_ADVANCE;
        return req;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
    endfunction

    function automatic int fold_end(input int s, input int d);
        if (s + d > COORD_MAX || s + d < COORD_MIN)
            return s - d;
        return s + d;
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 12);
        if (r < 95)
            return $urandom_range(13, 80);
        return $urandom_range(81, 300);
    endfunction

    function automatic in_item_t make_line(input int span);
        int sx;
        int sy;
        int major;
        int minor;
        sx = rand_coord();
        sy = rand_coord();
        major = $urandom_range(1) ? span : -span;
        minor = int'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(1))
            return start_req(sx, sy, fold_end(sx, major), fold_end(sy, minor));
        return start_req(sx, sy, fold_end(sx, minor), fold_end(sy, major));
    endfunction

    task automatic send_request(input in_item_t req);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (req.command == CMD_START)
        begin
            open_points = line_span(req) + 1;
            useful_sent++;
        end
        else if (open_points > 0)
        begin
            open_points--;
            useful_sent++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_style(input logic [1:0] style);
        style_we <= 1'b1;
        style_wdata <= style;
        @(posedge clk);
        style_we <= 1'b0;
    endtask

    task automatic run_traffic(input int n_req);
        int       goal;
        int       kind;
        int       adv;
        in_item_t req;
        goal = useful_sent + n_req;
        while (useful_sent < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 82)
            begin
                req = make_line(pick_span());
                send_request(req);
                adv = open_points;
                // broken line, cut short by the next start
                if (kind < 8)
                    adv = $urandom_range(0, open_points);
                repeat (adv) send_request(rand_advance());
            end
            else if (kind < 92)
                send_request(rand_advance());
            else
            begin
                send_request(start_req(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
                repeat ($urandom_range(0, 6)) send_request(rand_advance());
            end
        end
    endtask

    task automatic test_directed();
        // advance with no line
        send_request(rand_advance());
        // equal endpoints give one point
        send_request(start_req(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        repeat (2) send_request(rand_advance());
        // full-range diagonal, dropped by the next start
        send_request(start_req(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        repeat (3) send_request(rand_advance());
        send_request(start_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        repeat (2) send_request(rand_advance());
        // short steep line run to its end
        send_request(start_req(COORD_MIN, COORD_MIN, COORD_MIN + 3, COORD_MIN + 7));
        repeat (8) send_request(rand_advance());
        send_request(start_req(5, 3, -2, -4));
        repeat (8) send_request(rand_advance());
    endtask

    task automatic test_style_sweep();
        logic [1:0] styles[4];
        styles = '{STYLE_SOLID, STYLE_DOTTED, STYLE_DASHED, STYLE_SIMPLE};
        foreach (styles[i])
        begin
            wait_drained();
            write_style(styles[i]);
            run_traffic(150);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        write_style(STYLE_DASHED);
        hold_req = HOLD_CYCLES;
        send_request(start_req(-100, 50, -40, 20));
        repeat (61) send_request(rand_advance());
        wait_drained();
        run_traffic(40);
    endtask

    task automatic test_no_idle();
        wait_drained();
        write_style(STYLE_DOTTED);
        no_idle = 1'b1;
        run_traffic(120);
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_style_sweep();
        test_backpressure();
        test_no_idle();
        wait_drained();
        if (mismatches == 0 && pending_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
